// ----- rtl/bltrk_pkg.sv -----
// ----------------------------------------------------------------------------
// bltrk_pkg
// Shared widths, codes and control-word types for the battery level and
// charge tracker.
// ----------------------------------------------------------------------------
package bltrk_pkg;

  localparam int MV_W     = 13;  // millivolt fields
  localparam int PCT_W    = 7;   // percent fields
  localparam int NUM_W    = 20;  // (sample - empty) * 100
  localparam int SUM_W    = 17;  // signed trend sum
  localparam int CNT_W    = 3;   // pair count, ring pointers
  localparam int STEP_W   = 3;   // microprogram step counter
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int HIST_DEPTH = 5;
  localparam int PAIRS      = HIST_DEPTH - 1;

  localparam logic [PCT_W-1:0] LEVEL_FULL = PCT_W'(100);

  // register indexes on the configuration port
  localparam logic [2:0] REG_FULL      = 3'd0;
  localparam logic [2:0] REG_EMPTY     = 3'd1;
  localparam logic [2:0] REG_STEP      = 3'd2;
  localparam logic [2:0] REG_HIGH      = 3'd3;
  localparam logic [2:0] REG_MID       = 3'd4;
  localparam logic [2:0] REG_DISC      = 3'd5;
  localparam logic [2:0] REG_FULL_HOLD = 3'd6;

  // microprogram entry points
  localparam logic [STEP_W-1:0] ST_LVL_CHK = 3'd0;
  localparam logic [STEP_W-1:0] ST_DIV     = 3'd2;
  localparam logic [STEP_W-1:0] ST_HIST    = 3'd4;
  localparam logic [STEP_W-1:0] ST_WALK    = 3'd5;
  localparam logic [STEP_W-1:0] ST_DECIDE  = 3'd6;

  typedef enum logic [2:0] {
    OP_LVL_CHK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_HYST,
    OP_HIST_WR,
    OP_WALK,
    OP_DECIDE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_CLAMP,
    C_DIV_MORE,
    C_FEW,
    C_WALK_MORE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [MV_W-1:0]  full_mv;
    logic [MV_W-1:0]  empty_mv;
    logic [PCT_W-1:0] level_step;
    logic [MV_W-1:0]  high_mv;
    logic [MV_W-1:0]  mid_mv;
    logic [MV_W-1:0]  disconnect_mv;
    logic [MV_W-1:0]  full_hold_mv;
  } cfg_t;

  typedef struct packed {
    logic clamp;
    logic div_more;
    logic few;
    logic walk_more;
  } stat_t;

  typedef struct packed {
    logic [PCT_W-1:0] level_pct;
    logic             charging;
    logic             level_changed;
    logic             charging_changed;
  } result_t;

endpackage

// ----- rtl/bltrk_ucode.sv -----
// ----------------------------------------------------------------------------
// bltrk_ucode
// Control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module bltrk_ucode (
  input  logic [bltrk_pkg::STEP_W-1:0] step_i,
  output bltrk_pkg::ctrl_t             ctrl_o
);
  import bltrk_pkg::*;

  always_comb begin
    case (step_i)
      3'd0:    ctrl_o = '{op: OP_LVL_CHK,  cond: C_CLAMP,     target: ST_HIST};
      3'd1:    ctrl_o = '{op: OP_DIV_INIT, cond: C_NEXT,      target: ST_LVL_CHK};
      3'd2:    ctrl_o = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: ST_DIV};
      3'd3:    ctrl_o = '{op: OP_HYST,     cond: C_NEXT,      target: ST_LVL_CHK};
      3'd4:    ctrl_o = '{op: OP_HIST_WR,  cond: C_FEW,       target: ST_DECIDE};
      3'd5:    ctrl_o = '{op: OP_WALK,     cond: C_WALK_MORE, target: ST_WALK};
      3'd6:    ctrl_o = '{op: OP_DECIDE,   cond: C_NEXT,      target: ST_LVL_CHK};
      default: ctrl_o = '{op: OP_EMIT,     cond: C_NEXT,      target: ST_LVL_CHK};
    endcase
  end

endmodule

// ----- rtl/bltrk_dp.sv -----
// ----------------------------------------------------------------------------
// bltrk_dp
// Datapath: level interpolation with a bit-serial divider, hysteresis,
// history ring walk and charging decision, steered by the control word.
// ----------------------------------------------------------------------------
module bltrk_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bltrk_pkg::cfg_t            cfg_i,
  input  logic                       load_i,
  input  logic [bltrk_pkg::MV_W-1:0] sample_i,
  input  logic                       exec_i,
  input  bltrk_pkg::ctrl_t           ctrl_i,
  output bltrk_pkg::stat_t           stat_o,
  output bltrk_pkg::result_t         result_o
);
  import bltrk_pkg::*;

  // persistent state
  logic [PCT_W-1:0] held_q, held_d;
  logic             first_q, first_d;
  logic [MV_W-1:0]  hist_q [HIST_DEPTH];
  logic [CNT_W-1:0] ring_q, ring_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [PCT_W-1:0] last_lvl_q, last_lvl_d;
  logic             last_chg_q, last_chg_d;
  logic             hist_we;

  // working registers
  logic [MV_W-1:0]         sample_q, sample_d;
  logic [NUM_W-1:0]        rem_q, rem_d;
  logic [MV_W-1:0]         den_q, den_d;
  logic [PCT_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]        wptr_q, wptr_d;
  logic [CNT_W-1:0]        walk_cnt_q, walk_cnt_d;
  logic [MV_W-1:0]         prev_q, prev_d;
  logic signed [SUM_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [PCT_W-1:0]        lvl_q, lvl_d;
  logic                    chg_q, chg_d;

  // combinational helpers
  logic                    at_full, at_empty;
  logic [CNT_W-1:0]        ring_inc, wptr_inc;
  logic [MV_W-1:0]         cur;
  logic [NUM_W-1:0]        trial;
  logic [PCT_W-1:0]        lvl_diff;
  logic signed [SUM_W-1:0] cnt_s, c3, c6, c11, thr1;
  logic                    above_thr, ge_m2, in_band, ovr_high, ovr_hold;

  assign at_full  = sample_q >= cfg_i.full_mv;
  assign at_empty = sample_q <= cfg_i.empty_mv;
  assign ring_inc = (ring_q == CNT_W'(HIST_DEPTH - 1)) ? '0 : ring_q + CNT_W'(1);
  assign wptr_inc = (wptr_q == CNT_W'(HIST_DEPTH - 1)) ? '0 : wptr_q + CNT_W'(1);
  assign cur      = hist_q[wptr_q];
  assign trial    = NUM_W'(den_q) << div_cnt_q;
  assign lvl_diff = (quo_q >= held_q) ? quo_q - held_q : held_q - quo_q;

  // truncating average compared through count multiples
  assign cnt_s     = $signed({{(SUM_W-CNT_W){1'b0}}, cnt_q});
  assign c3        = (cnt_s <<< 1) + cnt_s;
  assign c6        = c3 <<< 1;
  assign c11       = (cnt_s <<< 3) + c3;
  assign thr1      = (sample_q >= cfg_i.high_mv) ? c3 :
                     (sample_q >= cfg_i.mid_mv)  ? c6 : c11;
  assign above_thr = total_q >= thr1;
  assign ge_m2     = total_q > -c3;
  assign in_band   = (total_q > -c6) && (total_q < c6);
  assign ovr_high  = (sample_q >= cfg_i.high_mv) && ge_m2;
  assign ovr_hold  = (sample_q >= cfg_i.full_hold_mv) && in_band;

  assign stat_o.clamp     = at_full || at_empty;
  assign stat_o.div_more  = div_cnt_q != '0;
  assign stat_o.few       = seen_q < CNT_W'(PAIRS - 1);
  assign stat_o.walk_more = walk_cnt_q != CNT_W'(HIST_DEPTH - 1);

  assign result_o.level_pct        = lvl_q;
  assign result_o.charging         = chg_q;
  assign result_o.level_changed    = lvl_q != last_lvl_q;
  assign result_o.charging_changed = chg_q != last_chg_q;

  always_comb begin
    held_d     = held_q;
    first_d    = first_q;
    ring_d     = ring_q;
    seen_d     = seen_q;
    last_lvl_d = last_lvl_q;
    last_chg_d = last_chg_q;
    hist_we    = 1'b0;
    sample_d   = load_i ? sample_i : sample_q;
    rem_d      = rem_q;
    den_d      = den_q;
    quo_d      = quo_q;
    div_cnt_d  = div_cnt_q;
    wptr_d     = wptr_q;
    walk_cnt_d = walk_cnt_q;
    prev_d     = prev_q;
    total_d    = total_q;
    cnt_d      = cnt_q;
    lvl_d      = lvl_q;
    chg_d      = chg_q;
    if (exec_i) begin
      case (ctrl_i.op)
        OP_LVL_CHK: begin
          lvl_d = at_full ? LEVEL_FULL : '0;
        end
        OP_DIV_INIT: begin
          rem_d     = NUM_W'(sample_q - cfg_i.empty_mv) * NUM_W'(LEVEL_FULL);
          den_d     = cfg_i.full_mv - cfg_i.empty_mv;
          quo_d     = '0;
          div_cnt_d = CNT_W'(PCT_W - 1);
        end
        OP_DIV_STEP: begin
          if (rem_q >= trial) begin
            rem_d            = rem_q - trial;
            quo_d[div_cnt_q] = 1'b1;
          end
          div_cnt_d = div_cnt_q - CNT_W'(1);
        end
        OP_HYST: begin
          if (first_q || (lvl_diff >= cfg_i.level_step)) begin
            held_d = quo_q;
            lvl_d  = quo_q;
          end else begin
            lvl_d  = held_q;
          end
          first_d = 1'b0;
        end
        OP_HIST_WR: begin
          hist_we    = 1'b1;
          ring_d     = ring_inc;
          wptr_d     = ring_inc;
          seen_d     = (seen_q < CNT_W'(PAIRS)) ? seen_q + CNT_W'(1) : seen_q;
          walk_cnt_d = '0;
          total_d    = '0;
          cnt_d      = '0;
        end
        OP_WALK: begin
          // pair the previous entry with this one, oldest to newest
          if ((walk_cnt_q != '0) && (prev_q != '0) && (cur != '0)) begin
            total_d = total_q + $signed({{(SUM_W-MV_W){1'b0}}, cur})
                              - $signed({{(SUM_W-MV_W){1'b0}}, prev_q});
            cnt_d   = cnt_q + CNT_W'(1);
          end
          prev_d     = cur;
          wptr_d     = wptr_inc;
          walk_cnt_d = walk_cnt_q + CNT_W'(1);
        end
        OP_DECIDE: begin
          chg_d = (cnt_q != '0) && (sample_q >= cfg_i.disconnect_mv)
                  && (above_thr || ovr_high || ovr_hold);
        end
        OP_EMIT: begin
          last_lvl_d = lvl_q;
          last_chg_d = chg_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      first_q    <= 1'b1;
      ring_q     <= '0;
      seen_q     <= '0;
      last_lvl_q <= '0;
      last_chg_q <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      held_q     <= held_d;
      first_q    <= first_d;
      ring_q     <= ring_d;
      seen_q     <= seen_d;
      last_lvl_q <= last_lvl_d;
      last_chg_q <= last_chg_d;
      if (hist_we) begin
        hist_q[ring_q] <= sample_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    div_cnt_q  <= div_cnt_d;
    wptr_q     <= wptr_d;
    walk_cnt_q <= walk_cnt_d;
    prev_q     <= prev_d;
    total_q    <= total_d;
    cnt_q      <= cnt_d;
    lvl_q      <= lvl_d;
    chg_q      <= chg_d;
  end

endmodule

// ----- rtl/battery_level_and_charge_tracker.sv -----
// ----------------------------------------------------------------------------
// battery_level_and_charge_tracker
// Battery level and charging trend tracker with APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_mv_i) takes one averaged
//   battery voltage in mV per item. A zero sample is taken and dropped: it
//   gives no result and changes no state.
//   Output channel (out_valid_o / out_stall_i) returns one item per nonzero
//   sample: level percent, charging flag and two change flags.
//   A short microprogram runs each sample: a level check; for a level that is
//   not clamped, a 7-step serial divider for interpolation and a hysteresis
//   step; a history write; once the history holds enough samples, a 5-step
//   walk of the history ring; the charging decision and the emit step. No new
//   item is taken while one is worked; the next item can be taken in the cycle
//   after the emit step.
//   While the receiver stalls, the result holds in the output register and
//   the block keeps taking and working an item; its emit step waits until
//   the output register is free.
//   Reset restores the default thresholds, clears history and trend counts
//   and marks the first interpolated level to be taken as is. Registers are
//   to be written over APB only while the block is idle: it is not enforced.
// ----------------------------------------------------------------------------
module battery_level_and_charge_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bltrk_pkg::MV_W-1:0]         sample_mv_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bltrk_pkg::PCT_W-1:0]        level_pct_o,
  output logic                               charging_o,
  output logic                               level_changed_o,
  output logic                               charging_changed_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bltrk_pkg::ADDR_W-1:0]       paddr,
  input  logic [bltrk_pkg::DATA_W-1:0]       pwdata,
  output logic [bltrk_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);
  import bltrk_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [2:0]        reg_idx;
  logic              cfg_we;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  ctrl_t             ctrl;
  stat_t             stat;
  result_t           result;
  logic              accept, load, hold, exec, jump, emit;

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_FULL:      cfg_d.full_mv       = pwdata[MV_W-1:0];
        REG_EMPTY:     cfg_d.empty_mv      = pwdata[MV_W-1:0];
        REG_STEP:      cfg_d.level_step    = pwdata[PCT_W-1:0];
        REG_HIGH:      cfg_d.high_mv       = pwdata[MV_W-1:0];
        REG_MID:       cfg_d.mid_mv        = pwdata[MV_W-1:0];
        REG_DISC:      cfg_d.disconnect_mv = pwdata[MV_W-1:0];
        REG_FULL_HOLD: cfg_d.full_hold_mv  = pwdata[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FULL:      prdata = DATA_W'(cfg_q.full_mv);
      REG_EMPTY:     prdata = DATA_W'(cfg_q.empty_mv);
      REG_STEP:      prdata = DATA_W'(cfg_q.level_step);
      REG_HIGH:      prdata = DATA_W'(cfg_q.high_mv);
      REG_MID:       prdata = DATA_W'(cfg_q.mid_mv);
      REG_DISC:      prdata = DATA_W'(cfg_q.disconnect_mv);
      REG_FULL_HOLD: prdata = DATA_W'(cfg_q.full_hold_mv);
      default:       prdata = '0;
    endcase
  end

  // ---------------- sequencer
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign load       = accept && (sample_mv_i != '0);
  assign hold       = (ctrl.op == OP_EMIT) && out_valid_q && out_stall_i;
  assign exec       = busy_q && !hold;
  assign emit       = exec && (ctrl.op == OP_EMIT);

  always_comb begin
    case (ctrl.cond)
      C_CLAMP:     jump = stat.clamp;
      C_DIV_MORE:  jump = stat.div_more;
      C_FEW:       jump = stat.few;
      C_WALK_MORE: jump = stat.walk_more;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = ST_LVL_CHK;
    end else if (emit) begin
      busy_d = 1'b0;
    end else if (exec) begin
      step_d = jump ? ctrl.target : step_q + STEP_W'(1);
    end
  end

  // hold the result while the receiver stalls
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_mv       <= MV_W'(4200);
      cfg_q.empty_mv      <= MV_W'(3000);
      cfg_q.level_step    <= PCT_W'(2);
      cfg_q.high_mv       <= MV_W'(4000);
      cfg_q.mid_mv        <= MV_W'(3900);
      cfg_q.disconnect_mv <= MV_W'(2500);
      cfg_q.full_hold_mv  <= MV_W'(4150);
      busy_q              <= 1'b0;
      step_q              <= ST_LVL_CHK;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign level_pct_o        = out_q.level_pct;
  assign charging_o         = out_q.charging;
  assign level_changed_o    = out_q.level_changed;
  assign charging_changed_o = out_q.charging_changed;

  bltrk_ucode u_ucode (
    .step_i (step_q),
    .ctrl_o (ctrl)
  );

  bltrk_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .load_i   (load),
    .sample_i (sample_mv_i),
    .exec_i   (exec),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result)
  );

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery level and charge tracker. Samples are
// driven over the valid/stall input channel and results are checked against
// an in-bench tracker model held in a small scoreboard. The thresholds are
// rewritten over APB between phases. Both channels idle at random, and one
// long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bltrk_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 255;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_MV         = 8191;
  localparam int DIRECTED_ITEMS = 25;

  // trend thresholds and override windows
  localparam int THR_HIGH   = 2;
  localparam int THR_MID    = 5;
  localparam int THR_LOW    = 10;
  localparam int HIGH_FLOOR = -2;
  localparam int FLAT_SPAN  = 5;

  class level_scoreboard;
    int unsigned full_mv, empty_mv, level_step, high_mv, mid_mv, disc_mv, hold_mv;
    int unsigned held_level, ring_pos, seen_count, last_level;
    bit          first_pending, last_charging;
    int unsigned history [HIST_DEPTH];
    result_t     expected_q [$];
    int unsigned errors;

    function new();
      full_mv       = 4200;
      empty_mv      = 3000;
      level_step    = 2;
      high_mv       = 4000;
      mid_mv        = 3900;
      disc_mv       = 2500;
      hold_mv       = 4150;
      held_level    = 0;
      first_pending = 1'b1;
      ring_pos      = 0;
      seen_count    = 0;
      last_level    = 0;
      last_charging = 1'b0;
      errors        = 0;
      foreach (history[i]) history[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_FULL:      full_mv    = 32'(data[MV_W-1:0]);
        REG_EMPTY:     empty_mv   = 32'(data[MV_W-1:0]);
        REG_STEP:      level_step = 32'(data[PCT_W-1:0]);
        REG_HIGH:      high_mv    = 32'(data[MV_W-1:0]);
        REG_MID:       mid_mv     = 32'(data[MV_W-1:0]);
        REG_DISC:      disc_mv    = 32'(data[MV_W-1:0]);
        REG_FULL_HOLD: hold_mv    = 32'(data[MV_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(logic [MV_W-1:0] sample);
      int unsigned v, raw, diff, lvl, i;
      int          total, count, avg, thr, a, b;
      bit          chg;
      result_t     r;
      v = 32'(sample);
      // a failed read leaves everything as it was
      if (v == 0) return;
      if (v >= full_mv) lvl = 100;
      else if (v <= empty_mv) lvl = 0;
      else begin
        raw = ((v - empty_mv) * 100) / (full_mv - empty_mv);
        if (first_pending) begin
          held_level    = raw;
          first_pending = 1'b0;
        end else begin
          diff = (raw >= held_level) ? raw - held_level : held_level - raw;
          if (diff >= level_step) held_level = raw;
        end
        lvl = held_level;
      end

      history[ring_pos] = v;
      ring_pos = (ring_pos + 1) % HIST_DEPTH;
      if (seen_count < 4) seen_count++;
      chg = 1'b0;
      if (seen_count >= 4) begin
        total = 0;
        count = 0;
        // walk oldest to newest, skipping pairs with an empty slot
        for (i = 0; i < PAIRS; i++) begin
          a = history[(ring_pos + i) % HIST_DEPTH];
          b = history[(ring_pos + i + 1) % HIST_DEPTH];
          if (a != 0 && b != 0) begin
            total += b - a;
            count++;
          end
        end
        if (count != 0) begin
          avg = total / count;
          if (v >= high_mv) thr = THR_HIGH;
          else if (v >= mid_mv) thr = THR_MID;
          else thr = THR_LOW;
          chg = (avg > thr);
          if (v < disc_mv) chg = 1'b0;
          else begin
            if (v >= high_mv && avg >= HIGH_FLOOR) chg = 1'b1;
            if (v >= hold_mv && avg >= -FLAT_SPAN && avg <= FLAT_SPAN) chg = 1'b1;
          end
        end
      end

      r.level_pct        = PCT_W'(lvl);
      r.charging         = chg;
      r.level_changed    = (lvl != last_level);
      r.charging_changed = (chg != last_charging);
      last_level    = lvl;
      last_charging = chg;
      expected_q.push_back(r);
    endfunction

    task flag_mismatch(string what, int got, int want);
      errors++;
      $display("ERROR %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected item, level_pct", int'(got.level_pct), -1);
        return;
      end
      want = expected_q.pop_front();
      if (got.level_pct !== want.level_pct)
        flag_mismatch("level_pct", int'(got.level_pct), int'(want.level_pct));
      if (got.charging !== want.charging)
        flag_mismatch("charging", int'(got.charging), int'(want.charging));
      if (got.level_changed !== want.level_changed)
        flag_mismatch("level_changed", int'(got.level_changed),
                      int'(want.level_changed));
      if (got.charging_changed !== want.charging_changed)
        flag_mismatch("charging_changed", int'(got.charging_changed),
                      int'(want.charging_changed));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [MV_W-1:0]     sample_mv_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PCT_W-1:0]    level_pct_o;
  logic                charging_o;
  logic                level_changed_o;
  logic                charging_changed_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  level_scoreboard sb = new();

  int send_idle;
  int recv_idle;
  int hold_requests;
  int walk_mv;
  int walk_slope;

  battery_level_and_charge_tracker uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_mv_i        (sample_mv_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .level_pct_o        (level_pct_o),
    .charging_o         (charging_o),
    .level_changed_o    (level_changed_o),
    .charging_changed_o (charging_changed_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // both channels: note accepted samples, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_mv_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({level_pct_o, charging_o, level_changed_o, charging_changed_o});
    end
  end

  // receiver: random stalls, plus a long hold on request
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    #5ms;
    $display("battery_level_and_charge_tracker: mismatch");
    $finish;
  end

  task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // junk in the upper bits must be ignored
  task automatic load_config(int f, int e, int s, int h, int m, int d, int fh);
    apb_write(REG_FULL,      32'({$urandom(), 13'(f)}));
    apb_write(REG_EMPTY,     32'({$urandom(), 13'(e)}));
    apb_write(REG_STEP,      32'({$urandom(), 7'(s)}));
    apb_write(REG_HIGH,      32'({$urandom(), 13'(h)}));
    apb_write(REG_MID,       32'({$urandom(), 13'(m)}));
    apb_write(REG_DISC,      32'({$urandom(), 13'(d)}));
    apb_write(REG_FULL_HOLD, 32'({$urandom(), 13'(fh)}));
  endtask

  task automatic send_sample(logic [MV_W-1:0] v);
    in_valid_i  <= 1'b1;
    sample_mv_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain();
    // let the last accepted item reach the scoreboard first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // a trailing zero sample may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_anchor();
    case (3'($urandom_range(6)))
      REG_FULL:  return sb.full_mv;
      REG_EMPTY: return sb.empty_mv;
      REG_HIGH:  return sb.high_mv;
      REG_MID:   return sb.mid_mv;
      REG_DISC:  return sb.disc_mv;
      default:   return sb.hold_mv;
    endcase
  endfunction

  // mostly slow voltage ramps with noise; some dropouts and wild jumps
  function automatic logic [MV_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return MV_W'($urandom_range(MAX_MV));
    if (pick < 13) walk_mv = pick_anchor() + $urandom_range(40) - 20;
    if ($urandom_range(15) == 0) walk_slope = $urandom_range(50) - 25;
    walk_mv += walk_slope + $urandom_range(6) - 3;
    if (walk_mv < 1) begin
      walk_mv    = 1;
      walk_slope = $urandom_range(15);
    end
    if (walk_mv > MAX_MV) begin
      walk_mv    = MAX_MV;
      walk_slope = -$urandom_range(15);
    end
    return MV_W'(walk_mv);
  endfunction

  initial begin
    logic [MV_W-1:0] directed_mv [DIRECTED_ITEMS];
    int f, e;
    directed_mv = '{
      0, 8191, 1, 4200, 4199, 3000, 3001, 3600, 3610, 3700, 3950, 3965, 3980,
      0, 3995, 4000, 4100, 4150, 4152, 4148, 2400, 2600, 3905, 3920, 4160};
    send_idle     = 37;
    recv_idle     = 53;
    hold_requests = 0;
    walk_mv       = 3900;
    walk_slope    = 5;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_mv_i <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: edges of each band, hysteresis, trend and overrides
    foreach (directed_mv[i]) send_sample(directed_mv[i]);
    in_valid_i <= 1'b0;
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle = (phase < 2) ? 37 : (phase < 4) ? 53 : 0;
      recv_idle = (phase < 2) ? 53 : (phase < 4) ? 37 : 0;
      case (phase)
        0: load_config(4200, 3000, 2, 4000, 3900, 2500, 4150);
        1, 5: begin
          e = $urandom_range(3400, 2800);
          f = e + $urandom_range(1500, 200);
          load_config(f, e, $urandom_range(10), f - $urandom_range(300),
                      f - $urandom_range(500, 300), e - $urandom_range(600),
                      f - $urandom_range(100));
        end
        2: load_config(MAX_MV, 0, 0, MAX_MV, 0, 0, MAX_MV);
        // full below empty, step above the percent range
        3: load_config(1000, 5000, 127, 0, MAX_MV, MAX_MV, 0);
        default: begin
          f = $urandom_range(MAX_MV, 1);
          e = $urandom_range(f - 1);
          load_config(f, e, $urandom_range(127), $urandom_range(MAX_MV),
                      $urandom_range(MAX_MV), $urandom_range(MAX_MV),
                      $urandom_range(MAX_MV));
        end
      endcase
      walk_mv = pick_anchor();
      // fill the block behind a long output stall
      if (phase == 4) hold_requests++;
      repeat (PHASE_ITEMS) send_sample(next_sample());
      in_valid_i <= 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("battery_level_and_charge_tracker: match");
    end else begin
      $display("battery_level_and_charge_tracker: mismatch");
    end
    $finish;
  end

endmodule
